FILE: sv/wtri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed trapezoid integrator package
// Shared widths, register indexes, reset values and the types that pass
// between the front stage, the word queue and the back end.
// ----------------------------------------------------------------------------
package wtri_pkg;

   localparam int HISTORY_DEPTH_DEFAULT = 512;

   localparam int SAMPLE_W    = 16;
   localparam int PRODUCT_W   = 32;
   localparam int CFG_W       = 16;
   localparam int LOAD_W      = 32;
   localparam int QUOTIENT_W  = 32;
   localparam int DIGIT_W     = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int STEP_CNT_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_INTERVAL = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_CONSTANT = 1'd1;

   localparam logic [CFG_W-1:0] STEP_INTERVAL_RESET = 16'd256;
   localparam logic [CFG_W-1:0] TIME_CONSTANT_RESET = 16'd256;

   localparam logic [LOAD_W-1:0] LOAD_MAX = 32'h7FFF_FFFF;
   localparam logic [LOAD_W-1:0] LOAD_MIN = 32'h8000_0000;

   typedef struct packed {
      logic                        valid;
      logic signed [PRODUCT_W-1:0] product;
   } wtri_push_type;

   typedef struct packed {
      logic                        full;
      logic                        empty;
      logic signed [PRODUCT_W-1:0] product;
   } wtri_queue_status_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EVICT = 7'b0000010,
      ST_OLD   = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_CHK   = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_FIN   = 7'b1000000
   } wtri_back_state_type;

endpackage

FILE: sv/wtri_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wtri_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data_ff <= mem[read_address];
   end

   assign read_data = read_data_ff;

endmodule

FILE: sv/wtri_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrator front stage
// Accepts sample words, forms their Q16.16 product and hands it to the queue.
// ----------------------------------------------------------------------------
module wtri_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [wtri_pkg::SAMPLE_W-1:0]   req_environment_sample,
   input  logic signed [wtri_pkg::SAMPLE_W-1:0]   req_molecular_sample,
   input  logic                                   queue_full,
   output wtri_pkg::wtri_push_type                push
);
   import wtri_pkg::*;

   logic                        stage_valid_ff;
   logic                        stage_valid_in;
   logic signed [PRODUCT_W-1:0] stage_product_ff;
   logic signed [PRODUCT_W-1:0] stage_product_in;
   logic                        accept;

   assign req_stall = stage_valid_ff & queue_full;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      stage_valid_in   = accept | (stage_valid_ff & queue_full);
      stage_product_in = stage_product_ff;
      if (accept) begin
         stage_product_in = req_environment_sample * req_molecular_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_product_ff <= stage_product_in;
   end

   assign push.valid   = stage_valid_ff;
   assign push.product = stage_product_ff;

endmodule

FILE: sv/wtri_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrator word queue
// Two-entry queue of products between the front stage and the back end.
// ----------------------------------------------------------------------------
module wtri_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  wtri_pkg::wtri_push_type         push,
   input  logic                            pop,
   output wtri_pkg::wtri_queue_status_type status
);
   import wtri_pkg::*;

   logic signed [PRODUCT_W-1:0] entry_ff [2];
   logic                        wr_ptr_ff;
   logic                        wr_ptr_in;
   logic                        rd_ptr_ff;
   logic                        rd_ptr_in;
   logic [1:0]                  count_ff;
   logic [1:0]                  count_in;
   logic                        full;
   logic                        empty;
   logic                        do_push;
   logic                        do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push.valid & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.product;
      end
   end

   assign status.full    = full;
   assign status.empty   = empty;
   assign status.product = entry_ff[rd_ptr_ff];

endmodule

FILE: sv/wtri_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrator back end
// Keeps the product ring and running sum, forms the trapezoid numerator,
// scales it by the step width over 16-bit digits and divides by twice tau
// one quotient bit per cycle, then saturates into the result register.
// ----------------------------------------------------------------------------
module wtri_back #(
   parameter int HISTORY_DEPTH = wtri_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wtri_pkg::wtri_queue_status_type      queue_status,
   output logic                                 queue_pop,
   input  logic [wtri_pkg::CFG_W-1:0]           step_interval,
   input  logic [wtri_pkg::CFG_W-1:0]           time_constant,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [wtri_pkg::LOAD_W-1:0]   rsp_load_value,
   output logic                                 rsp_tau_error
);
   import wtri_pkg::*;

   localparam int PTR_W   = $clog2(HISTORY_DEPTH);
   localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W   = PRODUCT_W + CNT_W;
   localparam int NUM_W   = SUM_W + 2;
   localparam int CHUNKS  = (NUM_W + DIGIT_W - 1) / DIGIT_W;
   localparam int MAG_W   = CHUNKS * DIGIT_W;
   localparam int ACC_W   = MAG_W + DIGIT_W;
   localparam int HIGH_W  = ACC_W - QUOTIENT_W;
   localparam int DIV_W   = CFG_W + 1;

   localparam logic [PTR_W-1:0]      LAST_SLOT  = PTR_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0]      FULL_COUNT = CNT_W'(HISTORY_DEPTH);
   localparam logic [CNT_W-1:0]      NEAR_FULL  = CNT_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0]      MIN_HELD   = CNT_W'(2);
   localparam logic [STEP_CNT_W-1:0] MUL_LAST   = STEP_CNT_W'(CHUNKS - 1);
   localparam logic [STEP_CNT_W-1:0] DIV_LAST   = STEP_CNT_W'(QUOTIENT_W - 1);

   wtri_back_state_type         state_ff;
   wtri_back_state_type         state_in;
   logic signed [PRODUCT_W-1:0] product_ff;
   logic signed [PRODUCT_W-1:0] product_in;
   logic [PTR_W-1:0]            wp_ff;
   logic [PTR_W-1:0]            wp_in;
   logic [CNT_W-1:0]            held_ff;
   logic [CNT_W-1:0]            held_in;
   logic signed [SUM_W-1:0]     sum_ff;
   logic signed [SUM_W-1:0]     sum_in;
   logic [MAG_W-1:0]            mag_ff;
   logic [MAG_W-1:0]            mag_in;
   logic                        neg_ff;
   logic                        neg_in;
   logic                        zero_ff;
   logic                        zero_in;
   logic                        err_ff;
   logic                        err_in;
   logic [ACC_W-1:0]            acc_ff;
   logic [ACC_W-1:0]            acc_in;
   logic [DIV_W-1:0]            rem_ff;
   logic [DIV_W-1:0]            rem_in;
   logic [QUOTIENT_W-1:0]       quo_ff;
   logic [QUOTIENT_W-1:0]       quo_in;
   logic                        ovf_ff;
   logic                        ovf_in;
   logic [STEP_CNT_W-1:0]       cnt_ff;
   logic [STEP_CNT_W-1:0]       cnt_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [LOAD_W-1:0]           load_ff;
   logic [LOAD_W-1:0]           load_in;
   logic                        tau_err_ff;
   logic                        tau_err_in;

   logic [PTR_W-1:0]            wp_next;
   logic [PTR_W-1:0]            oldest_addr;
   logic [PTR_W-1:0]            ram_raddr;
   logic                        ram_we;
   logic [PRODUCT_W-1:0]        ram_rdata;
   logic signed [PRODUCT_W-1:0] ring_word;
   logic                        ring_full;
   logic signed [SUM_W-1:0]     evicted;
   logic signed [NUM_W-1:0]     sum_wide;
   logic signed [NUM_W-1:0]     num;
   logic [NUM_W-1:0]            num_mag;
   logic [2*DIGIT_W-1:0]        partial;
   logic [HIGH_W-1:0]           high_part;
   logic [DIV_W-1:0]            divisor;
   logic [DIV_W:0]              trial;
   logic [DIV_W:0]              trial_diff;
   logic                        trial_ge;
   logic [LOAD_W-1:0]           result;
   logic                        out_free;

   wtri_ram #(
      .WIDTH (PRODUCT_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (wp_ff),
      .write_data    (product_ff),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   assign wp_next     = (wp_ff == LAST_SLOT) ? '0 : wp_ff + 1'b1;
   assign ring_full   = (held_ff == FULL_COUNT);
   assign oldest_addr = (held_ff >= NEAR_FULL) ? wp_next : '0;
   assign ram_we      = (state_ff == ST_EVICT);
   assign ram_raddr   = (state_ff == ST_EVICT) ? oldest_addr : wp_ff;
   assign ring_word   = $signed(ram_rdata);
   assign evicted     = ring_full ? SUM_W'(ring_word) : '0;

   assign sum_wide = NUM_W'(sum_ff);
   assign num      = (sum_wide <<< 1) - NUM_W'(ring_word) - NUM_W'(product_ff);
   assign num_mag  = num[NUM_W-1] ? (~num + 1'b1) : num;

   assign partial   = mag_ff[MAG_W-1 -: DIGIT_W] * step_interval;
   assign high_part = acc_ff[ACC_W-1 -: HIGH_W];
   assign divisor   = {time_constant, 1'b0};

   assign trial      = {rem_ff, quo_ff[QUOTIENT_W-1]};
   assign trial_diff = trial - {1'b0, divisor};
   assign trial_ge   = (trial >= {1'b0, divisor});

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      if (zero_ff) begin
         result = '0;
      end else if (neg_ff) begin
         if (ovf_ff || (quo_ff > LOAD_MIN)) begin
            result = LOAD_MIN;
         end else begin
            result = ~quo_ff + 1'b1;
         end
      end else begin
         if (ovf_ff || quo_ff[QUOTIENT_W-1]) begin
            result = LOAD_MAX;
         end else begin
            result = quo_ff;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      product_in   = product_ff;
      wp_in        = wp_ff;
      held_in      = held_ff;
      sum_in       = sum_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      err_in       = err_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      load_in      = load_ff;
      tau_err_in   = tau_err_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      queue_pop    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               queue_pop  = 1'b1;
               product_in = queue_status.product;
               state_in   = ST_EVICT;
            end
         end
         ST_EVICT: begin
            sum_in   = sum_ff + SUM_W'(product_ff) - evicted;
            wp_in    = wp_next;
            held_in  = ring_full ? held_ff : held_ff + 1'b1;
            state_in = ST_OLD;
         end
         ST_OLD: begin
            neg_in   = num[NUM_W-1];
            mag_in   = MAG_W'(num_mag);
            err_in   = (time_constant == '0);
            zero_in  = (held_ff < MIN_HELD) || (step_interval == '0)
                       || (time_constant == '0);
            ovf_in   = 1'b0;
            acc_in   = '0;
            cnt_in   = '0;
            state_in = zero_in ? ST_FIN : ST_MUL;
         end
         ST_MUL: begin
            acc_in = {acc_ff[ACC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + ACC_W'(partial);
            mag_in = {mag_ff[MAG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            ovf_in   = (HIGH_W'(divisor) <= high_part);
            rem_in   = high_part[DIV_W-1:0];
            quo_in   = acc_ff[QUOTIENT_W-1:0];
            cnt_in   = '0;
            state_in = ovf_in ? ST_FIN : ST_DIV;
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_in = {quo_ff[QUOTIENT_W-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               load_in      = result;
               tau_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         held_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         held_ff      <= held_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      product_ff <= product_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      zero_ff    <= zero_in;
      err_ff     <= err_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      ovf_ff     <= ovf_in;
      cnt_ff     <= cnt_in;
      load_ff    <= load_in;
      tau_err_ff <= tau_err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_load_value = load_ff;
   assign rsp_tau_error  = tau_err_ff;

endmodule

FILE: sv/windowed_trapezoid_integrator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed trapezoid integrator
// Channel | Ports            | Word
// request | req_valid        | environment_sample, molecular_sample (Q8.8)
//         | req_stall        |
// result  | rsp_valid        | load_value (Q16.16, saturated), tau_error
//         | rsp_stall        |
// config  | csr_write_enable | step_interval (index 0), time_constant (index 1)
//         | csr_index        |
//         | csr_write_data   |
//
// The back end takes one word at a time through pop, evict, numerator, a multiply
// step per 16-bit digit of the numerator, a check and the bit-serial divide by
// twice tau. Words with fewer than two products held, a zero step or a zero tau
// skip the multiply and divide, and a quotient past 32 bits skips the divide. A
// front stage and a two-entry queue keep taking words while the back end works or
// a result waits, until they fill. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module windowed_trapezoid_integrator_unit #(
   parameter int HISTORY_DEPTH = wtri_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [wtri_pkg::SAMPLE_W-1:0]   req_environment_sample,
   input  logic signed [wtri_pkg::SAMPLE_W-1:0]   req_molecular_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [wtri_pkg::LOAD_W-1:0]     rsp_load_value,
   output logic                                   rsp_tau_error,
   input  logic                                   csr_write_enable,
   input  logic [wtri_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [wtri_pkg::CFG_W-1:0]             csr_write_data
);
   import wtri_pkg::*;

   logic [CFG_W-1:0]      step_ff;
   logic [CFG_W-1:0]      step_in;
   logic [CFG_W-1:0]      tau_ff;
   logic [CFG_W-1:0]      tau_in;
   wtri_push_type         push;
   wtri_queue_status_type queue_status;
   logic                  queue_pop;

   always_comb begin
      step_in = step_ff;
      tau_in  = tau_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_STEP_INTERVAL: step_in = csr_write_data;
            CSR_TIME_CONSTANT: tau_in  = csr_write_data;
            default: begin
               step_in = step_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_INTERVAL_RESET;
         tau_ff  <= TIME_CONSTANT_RESET;
      end else begin
         step_ff <= step_in;
         tau_ff  <= tau_in;
      end
   end

   wtri_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_environment_sample (req_environment_sample),
      .req_molecular_sample   (req_molecular_sample),
      .queue_full             (queue_status.full),
      .push                   (push)
   );

   wtri_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (queue_pop),
      .status (queue_status)
   );

   wtri_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_status   (queue_status),
      .queue_pop      (queue_pop),
      .step_interval  (step_ff),
      .time_constant  (tau_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_load_value (rsp_load_value),
      .rsp_tau_error  (rsp_tau_error)
   );

   // A tau error always comes with a zero load value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tau_error |-> rsp_load_value == '0)
      else $error("tau error with nonzero load value");

   // The back end only pops a queue that holds a word.
   assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !queue_status.empty)
      else $error("pop from empty queue");

   // A front word that meets a full queue is still offered next cycle.
   assert property (@(posedge clock) disable iff (reset)
      push.valid && queue_status.full |=> push.valid && $stable(push.product))
      else $error("front word lost at full queue");

   // No result is shown in the cycle after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed trapezoid integrator testbench
// Drives sample words through the unit under bursty traffic and a stalling
// receiver. A scoreboard keeps its own product history and window sum, works
// out each expected load value and tau error, and checks every result word in
// order. Step width and tau are changed between phases, only while the unit
// is idle. The settings include zero, one and full scale.
// ----------------------------------------------------------------------------
module tb;
   import wtri_pkg::*;

   localparam int DEPTH = HISTORY_DEPTH_DEFAULT;

   typedef longint unsigned u64_t;

   typedef struct {
      logic signed [LOAD_W-1:0] load;
      logic                     tau_error;
   } load_result_t;

   class load_scoreboard;
      logic signed [PRODUCT_W-1:0] history [DEPTH];
      int                          wr_slot;
      int                          held;
      longint                      window_total;
      logic [CFG_W-1:0]            step_width;
      logic [CFG_W-1:0]            tau_q;
      load_result_t                pending_q [$];
      int                          failures;
      int                          checked;
      int                          nonzero_count;
      int                          saturated_count;
      int                          tau_error_count;
      bit                          window_filled;

      function new();
         for (int i = 0; i < DEPTH; i++) history[i] = '0;
         wr_slot = 0;
         held = 0;
         window_total = 0;
         step_width = STEP_INTERVAL_RESET;
         tau_q = TIME_CONSTANT_RESET;
         failures = 0;
         checked = 0;
         nonzero_count = 0;
         saturated_count = 0;
         tau_error_count = 0;
         window_filled = 0;
      endfunction

      function int outstanding();
         return pending_q.size();
      endfunction

      function void predict_sample(logic signed [SAMPLE_W-1:0] env_s,
                                   logic signed [SAMPLE_W-1:0] mol_s);
         longint       product;
         longint       numer;
         u64_t         magnitude;
         u64_t         quotient;
         u64_t         negated;
         int           oldest;
         int           newest;
         load_result_t r;
         product = longint'(env_s) * longint'(mol_s);
         if (held == DEPTH) window_total -= longint'(history[wr_slot]);
         history[wr_slot] = product[PRODUCT_W-1:0];
         window_total += product;
         wr_slot = (wr_slot + 1) % DEPTH;
         if (held < DEPTH) held++;
         if (held == DEPTH) window_filled = 1;
         r.load = '0;
         r.tau_error = 1'b0;
         if (tau_q == '0) begin
            r.tau_error = 1'b1;
         end else if (held >= 2 && step_width != '0) begin
            oldest = (wr_slot + DEPTH - held) % DEPTH;
            newest = (wr_slot + DEPTH - 1) % DEPTH;
            numer = 2 * window_total - longint'(history[oldest])
                    - longint'(history[newest]);
            magnitude = (numer < 0) ? u64_t'(-numer) : u64_t'(numer);
            quotient = (magnitude * u64_t'(step_width)) / (2 * u64_t'(tau_q));
            if (numer < 0) begin
               if (quotient > 64'h8000_0000) begin
                  r.load = LOAD_MIN;
                  saturated_count++;
               end else begin
                  negated = 64'd0 - quotient;
                  r.load = negated[LOAD_W-1:0];
               end
            end else if (quotient > 64'h7FFF_FFFF) begin
               r.load = LOAD_MAX;
               saturated_count++;
            end else begin
               r.load = quotient[LOAD_W-1:0];
            end
         end
         if (r.load != '0) nonzero_count++;
         if (r.tau_error) tau_error_count++;
         pending_q.push_back(r);
      endfunction

      function void compare_load(logic signed [LOAD_W-1:0] load, logic tau_error);
         load_result_t want;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result word load_value=%0d tau_error=%0b",
                     $time, load, tau_error);
            failures++;
            return;
         end
         want = pending_q.pop_front();
         checked++;
         if (load !== want.load) begin
            $display("%0t: load_value mismatch, expected %0d, actual %0d",
                     $time, want.load, load);
            failures++;
         end
         if (tau_error !== want.tau_error) begin
            $display("%0t: tau_error mismatch, expected %0b, actual %0b",
                     $time, want.tau_error, tau_error);
            failures++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic signed [SAMPLE_W-1:0]  req_environment_sample;
   logic signed [SAMPLE_W-1:0]  req_molecular_sample;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [LOAD_W-1:0]    rsp_load_value;
   logic                        rsp_tau_error;
   logic                        csr_write_enable;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [CFG_W-1:0]            csr_write_data;

   load_scoreboard sb = new();
   int             burst_left = 0;
   int             words_sent = 0;
   int             settings_used = 0;
   bit             hold_request = 0;

   windowed_trapezoid_integrator_unit #(.HISTORY_DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_environment_sample(req_environment_sample),
      .req_molecular_sample(req_molecular_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_load_value(rsp_load_value),
      .rsp_tau_error(rsp_tau_error),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.predict_sample(req_environment_sample, req_molecular_sample);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.compare_load(rsp_load_value, rsp_tau_error);
         end
      end
   end

   initial begin
      int hold_left;
      int run_left;
      int stall_pct;
      hold_left = 0;
      run_left = 0;
      stall_pct = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (run_left == 0) begin
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 30;
                  2: stall_pct = 70;
                  default: stall_pct = 95;
               endcase
               run_left = $urandom_range(4, 80);
            end
            run_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("** windowed_trapezoid_integrator_unit: FAILED **");
      $finish;
   end

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         1: return '0;
         2, 3: return SAMPLE_W'($urandom);
         default: return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      endcase
   endfunction

   task automatic send_word(logic signed [SAMPLE_W-1:0] env_s,
                            logic signed [SAMPLE_W-1:0] mol_s);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_environment_sample <= env_s;
      req_molecular_sample <= mol_s;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_settings(logic [CFG_W-1:0] step_w, logic [CFG_W-1:0] tau_w);
      wait_idle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_STEP_INTERVAL;
      csr_write_data <= step_w;
      @(negedge clock);
      csr_index <= CSR_TIME_CONSTANT;
      csr_write_data <= tau_w;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.step_width = step_w;
      sb.tau_q = tau_w;
      settings_used++;
   endtask

   initial begin
      logic [CFG_W-1:0] step_w;
      logic [CFG_W-1:0] tau_w;
      reset = 1'b1;
      req_valid = 1'b0;
      req_environment_sample = '0;
      req_molecular_sample = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_STEP_INTERVAL;
      csr_write_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The first word alone cannot form a window, so its load is zero.
      send_word(16'sh7FFF, 16'sh7FFF);
      send_word(16'sh8000, 16'sh8000);
      send_word(16'sh8000, 16'sh7FFF);
      send_word(16'sh0000, 16'sh0000);
      send_word(16'sh0001, 16'sh0001);
      send_word(16'shFFFF, 16'sh0001);
      send_word(16'sh00FF, 16'shFF00);

      apply_settings(16'd0, 16'd256);
      send_word(16'sh7FFF, 16'sh7FFF);
      send_word(16'sh1234, 16'sh4321);

      apply_settings(16'd256, 16'd0);
      send_word(16'sh7FFF, 16'sh7FFF);
      send_word(16'sh8000, 16'sh7FFF);

      apply_settings(16'hFFFF, 16'd1);
      repeat (4) send_word(16'sh8000, 16'sh7FFF);
      repeat (4) send_word(16'sh7FFF, 16'sh7FFF);

      apply_settings(16'd1, 16'hFFFF);
      send_word(16'sh0003, 16'sh0005);
      send_word(16'shFFFD, 16'sh0007);
      send_word(16'sh0100, 16'sh0100);

      for (int phase = 0; phase < 10; phase++) begin
         case ($urandom_range(0, 7))
            0: begin step_w = '0; tau_w = CFG_W'($urandom); end
            1: begin step_w = CFG_W'($urandom); tau_w = '0; end
            2: begin step_w = 16'hFFFF; tau_w = 16'hFFFF; end
            3: begin step_w = 16'd1; tau_w = 16'd1; end
            4: begin step_w = 16'd256; tau_w = 16'd256; end
            default: begin step_w = CFG_W'($urandom); tau_w = CFG_W'($urandom); end
         endcase
         apply_settings(step_w, tau_w);
         for (int i = 0; i < 153; i++) begin
            if (phase == 2 && i == 20) hold_request = 1;
            send_word(random_sample(), random_sample());
         end
      end

      wait_idle();
      repeat (60) @(negedge clock);
      if (sb.outstanding() != 0) begin
         $display("%0t: %0d result words never arrived", $time, sb.outstanding());
         sb.failures++;
      end
      $display("%0d words sent, %0d results checked over %0d register settings.",
               words_sent, sb.checked, settings_used);
      $display("%0d nonzero, %0d saturated, %0d tau errors, window filled: %0b.",
               sb.nonzero_count, sb.saturated_count, sb.tau_error_count,
               sb.window_filled);
      if (sb.failures == 0) begin
         $display("** windowed_trapezoid_integrator_unit: PASSED **");
      end else begin
         $display("** windowed_trapezoid_integrator_unit: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/wtri_pkg.sv
sv/wtri_ram.sv
sv/wtri_front.sv
sv/wtri_queue.sv
sv/wtri_back.sv
sv/windowed_trapezoid_integrator_unit.sv
sim/tb.sv
